[hdl/srtc_pkg.sv]
`default_nettype none
package srtc_pkg;

   // Full-scale position value; every divide in the datapath is by it.
   localparam int unsigned FULL_SCALE = 65535;

   localparam int unsigned POS_W   = 16;
   localparam int unsigned STEP_W  = 4;
   localparam int unsigned DELTA_W = 15;
   localparam int unsigned US_W    = 11;
   localparam int unsigned PULSE_W = 12;
   localparam int unsigned PROD_W  = 27;
   localparam int unsigned CODE_W  = 3;

   // Configuration register indexes.
   localparam logic [7:0] CSR_BISTABLE_MODE      = 8'd0;
   localparam logic [7:0] CSR_TRIGGER_ACTIVE_LOW = 8'd1;
   localparam logic [7:0] CSR_MIN_PULSE_US       = 8'd2;
   localparam logic [7:0] CSR_PULSE_SPAN_US      = 8'd3;

   localparam logic [US_W-1:0] MIN_PULSE_RESET  = 11'd1000;
   localparam logic [US_W-1:0] PULSE_SPAN_RESET = 11'd1000;

   // Step size per travel-time segment; entry i+1 is the interpolation target.
   localparam logic [DELTA_W-1:0] STEP_TABLE [17] = '{
      15'd131,  15'd164,  15'd218,  15'd262,  15'd328,  15'd437,  15'd524,  15'd655,
      15'd749,  15'd874,  15'd1049, 15'd1311, 15'd1748, 15'd2621, 15'd5243, 15'd13107,
      15'd26214
   };

   // Ramp position codes as they appear on the result channel.
   localparam logic [CODE_W-1:0] RAMP_CODE_IDLE  = 3'd0;
   localparam logic [CODE_W-1:0] RAMP_CODE_ATOB  = 3'd1;
   localparam logic [CODE_W-1:0] RAMP_CODE_ATTOP = 3'd2;
   localparam logic [CODE_W-1:0] RAMP_CODE_BTOA  = 3'd3;
   localparam logic [CODE_W-1:0] RAMP_CODE_WAIT  = 3'd4;

   typedef enum logic [2:0] {
      MUL_NONE  = 3'd0,
      MUL_GAP   = 3'd1,
      MUL_DIFF  = 3'd2,
      MUL_POSA  = 3'd3,
      MUL_PHASE = 3'd4
   } mul_src_type;

   typedef enum logic [1:0] {
      DIV_NONE = 2'd0,
      DIV_RNG  = 2'd1,
      DIV_OFF  = 2'd2,
      DIV_RES  = 2'd3
   } div_dst_type;

   typedef enum logic [1:0] {
      JUMP_NEXT = 2'd0,
      JUMP_IN   = 2'd1,
      JUMP_OUT  = 2'd2
   } jump_type;

   typedef struct packed {
      logic              take_in;
      mul_src_type       mul_src;
      div_dst_type       div_dst;
      logic              do_diff;
      logic              do_delta;
      logic              do_ramp;
      logic              do_out;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic in_fire;
      logic out_free;
   } seq_status_type;

   typedef struct packed {
      logic            bistable_mode;
      logic            trigger_active_low;
      logic [US_W-1:0] min_pulse_us;
      logic [US_W-1:0] pulse_span_us;
   } cfg_type;

endpackage
`default_nettype wire

[hdl/servo_ramp_trigger_controller_unit.sv]
`default_nettype none
// Servo ramp trigger controller. Each beat on the req_ channel is one servo
// period tick: positions A and B, a travel-time setting and the raw trigger
// pin. The block qualifies the trigger, steps the ramp state machine and its
// phasor, scales the phasor between A and B and returns one beat on rsp_
// with the pulse width, the ramp state and the phasor after the tick.
// Configuration registers (mode, trigger polarity, minimum pulse, pulse span)
// are written on the csr_ channel, ready whenever reset is low; the user must
// write them only while no tick is in flight, which the block leaves unchecked.
// A tick runs as an eleven-step microprogram: accept, step interpolation
// (multiply, add), ramp update, then three multiply/divide-by-65535 pairs on
// one shared 16x11 multiplier and a shift-and-correct divider, and a final
// add. A new tick is accepted only after the previous one has passed its
// final step, as the steps share the multiplier and the divider.
// The result sits in an output register, so the next tick is accepted while
// it waits. A stalled rsp_ only holds the sequencer at its final step.
// Reset is synchronous and active high: it clears the sequencer, the output
// valid, the ramp to idle with phasor zero and rising direction, and loads
// the register defaults (bistable, active low, 1000 us, 1000 us). Both input
// channels hold ready low while reset is high.
module servo_ramp_trigger_controller_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [15:0] pos_a, [31:16] pos_b, [47:32] travel_time, [48] trigger_pin, rest zero
   input  wire  [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [11:0] pulse_us, [14:12] ramp_state, [30:15] phase, [31] zero
   output logic [31:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_index,
   input  wire  [10:0] csr_data
);
   import srtc_pkg::*;

   cfg_type            cfg_ff;
   ctrl_type           ctrl;
   seq_status_type     status;
   logic               in_fire;
   logic               act;
   logic [DELTA_W-1:0] delta;
   logic [CODE_W-1:0]  state_code;
   logic [POS_W-1:0]   phase;
   logic               out_free;
   logic [PULSE_W-1:0] rsp_pulse_us;
   logic [CODE_W-1:0]  rsp_ramp_state;
   logic [POS_W-1:0]   rsp_phase;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bistable_mode      <= 1'b1;
         cfg_ff.trigger_active_low <= 1'b1;
         cfg_ff.min_pulse_us       <= MIN_PULSE_RESET;
         cfg_ff.pulse_span_us      <= PULSE_SPAN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BISTABLE_MODE:      cfg_ff.bistable_mode      <= csr_data[0];
            CSR_TRIGGER_ACTIVE_LOW: cfg_ff.trigger_active_low <= csr_data[0];
            CSR_MIN_PULSE_US:       cfg_ff.min_pulse_us       <= csr_data;
            CSR_PULSE_SPAN_US:      cfg_ff.pulse_span_us      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_tready      = ctrl.take_in && !reset;
   assign in_fire         = req_tvalid && req_tready;
   assign status.in_fire  = in_fire;
   assign status.out_free = out_free;

   srtc_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   srtc_ramp u_ramp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .cfg        (cfg_ff),
      .act        (act),
      .delta      (delta),
      .state_code (state_code),
      .phase      (phase)
   );

   srtc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .cfg            (cfg_ff),
      .in_fire        (in_fire),
      .pos_a          (req_tdata[15:0]),
      .pos_b          (req_tdata[31:16]),
      .travel_time    (req_tdata[47:32]),
      .trigger_pin    (req_tdata[48]),
      .state_code     (state_code),
      .phase          (phase),
      .rsp_ready      (rsp_tready),
      .act            (act),
      .delta          (delta),
      .out_free       (out_free),
      .rsp_valid      (rsp_tvalid),
      .rsp_pulse_us   (rsp_pulse_us),
      .rsp_ramp_state (rsp_ramp_state),
      .rsp_phase      (rsp_phase)
   );

   assign rsp_tdata = {1'b0, rsp_phase, rsp_ramp_state, rsp_pulse_us};

endmodule
`default_nettype wire

[hdl/srtc_useq.sv]
`default_nettype none
module srtc_useq (
   input  wire                      clock,
   input  wire                      reset,
   input  srtc_pkg::seq_status_type status,
   output srtc_pkg::ctrl_type       ctrl
);
   import srtc_pkg::*;

   localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_GAP   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DELTA = 4'd2;
   localparam logic [STEP_W-1:0] STEP_RAMP  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MRNG  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DRNG  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MOFF  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DOFF  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_MRES  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DRES  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_OUT   = 4'd10;

   localparam ctrl_type CTRL_NOP = '{
      take_in:  1'b0,
      mul_src:  MUL_NONE,
      div_dst:  DIV_NONE,
      do_diff:  1'b0,
      do_delta: 1'b0,
      do_ramp:  1'b0,
      do_out:   1'b0,
      jump:     JUMP_NEXT,
      target:   STEP_WAIT
   };

   // The control store: one word per step.
   function automatic ctrl_type program_word(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = CTRL_NOP;
      case (step)
         STEP_WAIT: begin
            w.take_in = 1'b1;
            w.jump    = JUMP_IN;
            w.target  = STEP_GAP;
         end
         STEP_GAP: begin
            w.mul_src = MUL_GAP;
            w.do_diff = 1'b1;
         end
         STEP_DELTA: w.do_delta = 1'b1;
         STEP_RAMP:  w.do_ramp  = 1'b1;
         STEP_MRNG:  w.mul_src  = MUL_DIFF;
         STEP_DRNG:  w.div_dst  = DIV_RNG;
         STEP_MOFF:  w.mul_src  = MUL_POSA;
         STEP_DOFF:  w.div_dst  = DIV_OFF;
         STEP_MRES:  w.mul_src  = MUL_PHASE;
         STEP_DRES:  w.div_dst  = DIV_RES;
         STEP_OUT: begin
            w.do_out = 1'b1;
            w.jump   = JUMP_OUT;
            w.target = STEP_WAIT;
         end
         default: begin
            w.jump   = JUMP_OUT;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   assign ctrl = program_word(step_ff);

   always_comb begin
      case (ctrl.jump)
         JUMP_NEXT: step_in = step_ff + 4'd1;
         JUMP_IN:   step_in = status.in_fire ? ctrl.target : step_ff;
         JUMP_OUT:  step_in = status.out_free ? ctrl.target : step_ff;
         default:   step_in = STEP_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

[hdl/srtc_ramp.sv]
`default_nettype none
module srtc_ramp (
   input  wire                             clock,
   input  wire                             reset,
   input  srtc_pkg::ctrl_type              ctrl,
   input  srtc_pkg::cfg_type               cfg,
   input  wire                             act,
   input  wire [srtc_pkg::DELTA_W-1:0]     delta,
   output logic [srtc_pkg::CODE_W-1:0]     state_code,
   output logic [srtc_pkg::POS_W-1:0]      phase
);
   import srtc_pkg::*;

   typedef enum logic [4:0] {
      RS_IDLE  = 5'b00001,
      RS_ATOB  = 5'b00010,
      RS_ATTOP = 5'b00100,
      RS_BTOA  = 5'b01000,
      RS_WAIT  = 5'b10000
   } ramp_state_type;

   ramp_state_type     state_ff;
   ramp_state_type     state_in;
   logic [POS_W-1:0]   phasor_ff;
   logic [POS_W-1:0]   phasor_in;
   logic               rising_ff;
   logic               rising_in;

   logic               dir;
   logic [POS_W:0]     up_sum;
   logic [POS_W:0]     down_sum;
   logic [POS_W-1:0]   adv_phase;
   logic               hit;

   // In follow mode a trigger change flips the direction before the move.
   always_comb begin
      dir = rising_ff;
      if (cfg.bistable_mode) begin
         if (state_ff == RS_ATOB && !act) begin
            dir = 1'b0;
         end else if (state_ff == RS_BTOA && act) begin
            dir = 1'b1;
         end
      end
   end

   assign up_sum   = {1'b0, phasor_ff} + {2'b00, delta};
   assign down_sum = {1'b0, phasor_ff} - {2'b00, delta};

   always_comb begin
      if (dir) begin
         hit       = up_sum[POS_W];
         adv_phase = up_sum[POS_W] ? {POS_W{1'b1}} : up_sum[POS_W-1:0];
      end else begin
         hit       = down_sum[POS_W];
         adv_phase = down_sum[POS_W] ? {POS_W{1'b0}} : down_sum[POS_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      phasor_in = phasor_ff;
      rising_in = rising_ff;
      if (cfg.bistable_mode) begin
         case (state_ff)
            RS_IDLE: begin
               if (act) begin
                  state_in  = RS_ATOB;
                  rising_in = 1'b1;
               end
            end
            RS_ATOB: begin
               if (!act) begin
                  state_in  = RS_BTOA;
                  rising_in = 1'b0;
               end
               phasor_in = adv_phase;
               // An end hit always sets the at-top state, even when heading back down.
               if (hit) begin
                  state_in = RS_ATTOP;
               end
            end
            RS_ATTOP: begin
               if (!act) begin
                  state_in  = RS_BTOA;
                  rising_in = 1'b0;
               end
            end
            RS_BTOA: begin
               if (act) begin
                  state_in  = RS_ATOB;
                  rising_in = 1'b1;
               end
               phasor_in = adv_phase;
               if (hit) begin
                  state_in = RS_IDLE;
               end
            end
            default: state_in = RS_IDLE;
         endcase
      end else begin
         case (state_ff)
            RS_IDLE: begin
               if (act) begin
                  state_in  = RS_ATOB;
                  rising_in = 1'b1;
               end
            end
            RS_ATOB: begin
               phasor_in = adv_phase;
               if (hit) begin
                  state_in  = RS_BTOA;
                  rising_in = 1'b0;
               end
            end
            RS_ATTOP: begin
               state_in  = RS_BTOA;
               rising_in = 1'b0;
            end
            RS_BTOA: begin
               phasor_in = adv_phase;
               if (hit) begin
                  state_in = RS_WAIT;
               end
            end
            RS_WAIT: begin
               if (!act) begin
                  state_in = RS_IDLE;
               end
            end
            default: state_in = RS_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= RS_IDLE;
         phasor_ff <= '0;
         rising_ff <= 1'b1;
      end else if (ctrl.do_ramp) begin
         state_ff  <= state_in;
         phasor_ff <= phasor_in;
         rising_ff <= rising_in;
      end
   end

   always_comb begin
      case (state_ff)
         RS_IDLE:  state_code = RAMP_CODE_IDLE;
         RS_ATOB:  state_code = RAMP_CODE_ATOB;
         RS_ATTOP: state_code = RAMP_CODE_ATTOP;
         RS_BTOA:  state_code = RAMP_CODE_BTOA;
         RS_WAIT:  state_code = RAMP_CODE_WAIT;
         default:  state_code = RAMP_CODE_IDLE;
      endcase
   end

   assign phase = phasor_ff;

endmodule
`default_nettype wire

[hdl/srtc_dpath.sv]
`default_nettype none
module srtc_dpath (
   input  wire                           clock,
   input  wire                           reset,
   input  srtc_pkg::ctrl_type            ctrl,
   input  srtc_pkg::cfg_type             cfg,
   input  wire                           in_fire,
   input  wire [srtc_pkg::POS_W-1:0]     pos_a,
   input  wire [srtc_pkg::POS_W-1:0]     pos_b,
   input  wire [srtc_pkg::POS_W-1:0]     travel_time,
   input  wire                           trigger_pin,
   input  wire [srtc_pkg::CODE_W-1:0]    state_code,
   input  wire [srtc_pkg::POS_W-1:0]     phase,
   input  wire                           rsp_ready,
   output logic                          act,
   output logic [srtc_pkg::DELTA_W-1:0]  delta,
   output logic                          out_free,
   output logic                          rsp_valid,
   output logic [srtc_pkg::PULSE_W-1:0]  rsp_pulse_us,
   output logic [srtc_pkg::CODE_W-1:0]   rsp_ramp_state,
   output logic [srtc_pkg::POS_W-1:0]    rsp_phase
);
   import srtc_pkg::*;

   logic [POS_W-1:0]   pos_a_ff;
   logic [POS_W-1:0]   pos_b_ff;
   logic [POS_W-1:0]   travel_ff;
   logic               pin_ff;
   logic [POS_W-1:0]   diff_mag_ff;
   logic               diff_neg_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic               prod_neg_ff;
   logic               prod_neg_in;
   logic [DELTA_W-1:0] delta_ff;
   logic [US_W-1:0]    rng_mag_ff;
   logic               rng_neg_ff;
   logic [US_W-1:0]    off_ff;
   logic [PULSE_W-1:0] part_ff;

   logic [3:0]         seg;
   logic [3:0]         frac;
   logic [DELTA_W-1:0] base;
   logic [DELTA_W-1:0] seg_span;
   logic [POS_W-1:0]   op_a;
   logic [US_W-1:0]    op_b;
   logic [US_W-1:0]    quo_hi;
   logic [POS_W:0]     rem_est;
   logic [US_W-1:0]    quo;
   logic [PULSE_W-1:0] part_in;
   logic [PULSE_W:0]   pulse_sum;
   logic               out_fire;

   assign act   = pin_ff ^ cfg.trigger_active_low;
   assign delta = delta_ff;

   assign seg      = travel_ff[15:12];
   assign frac     = travel_ff[11:8];
   assign base     = STEP_TABLE[{1'b0, seg}];
   assign seg_span = STEP_TABLE[{1'b0, seg} + 5'd1] - base;

   always_comb begin
      op_a        = '0;
      op_b        = '0;
      prod_neg_in = 1'b0;
      case (ctrl.mul_src)
         MUL_GAP: begin
            op_a = {5'b0, seg_span[DELTA_W-1:4]};
            op_b = {7'b0, frac};
         end
         MUL_DIFF: begin
            op_a        = diff_mag_ff;
            op_b        = cfg.pulse_span_us;
            prod_neg_in = diff_neg_ff;
         end
         MUL_POSA: begin
            op_a = pos_a_ff;
            op_b = cfg.pulse_span_us;
         end
         MUL_PHASE: begin
            op_a        = phase;
            op_b        = rng_mag_ff;
            prod_neg_in = rng_neg_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // Division by 65535: x>>16 is short by at most one, since the remainder
   // estimate (low half plus high half) stays below twice the divisor.
   assign quo_hi  = prod_ff[PROD_W-1:POS_W];
   assign rem_est = {1'b0, prod_ff[POS_W-1:0]} + {6'b0, quo_hi};
   assign quo     = quo_hi + US_W'(rem_est >= (POS_W+1)'(FULL_SCALE));

   assign part_in = prod_neg_ff ? (-{1'b0, quo}) : {1'b0, quo};

   assign pulse_sum = {2'b00, cfg.min_pulse_us} + {part_ff[PULSE_W-1], part_ff}
                    + {2'b00, off_ff};

   assign out_free = !rsp_valid || rsp_ready;
   assign out_fire = ctrl.do_out && out_free;

   always_ff @(posedge clock) begin
      if (in_fire) begin
         pos_a_ff  <= pos_a;
         pos_b_ff  <= pos_b;
         travel_ff <= travel_time;
         pin_ff    <= trigger_pin;
      end
      if (ctrl.do_diff) begin
         diff_neg_ff <= pos_b_ff < pos_a_ff;
         diff_mag_ff <= (pos_b_ff < pos_a_ff) ? (pos_a_ff - pos_b_ff) : (pos_b_ff - pos_a_ff);
      end
      if (ctrl.mul_src != MUL_NONE) begin
         prod_ff     <= prod_in;
         prod_neg_ff <= prod_neg_in;
      end
      if (ctrl.do_delta) begin
         delta_ff <= base + prod_ff[DELTA_W-1:0];
      end
      case (ctrl.div_dst)
         DIV_RNG: begin
            rng_mag_ff <= quo;
            rng_neg_ff <= prod_neg_ff;
         end
         DIV_OFF: off_ff  <= quo;
         DIV_RES: part_ff <= part_in;
         default: begin
         end
      endcase
      if (out_fire) begin
         rsp_pulse_us   <= pulse_sum[PULSE_W-1:0];
         rsp_ramp_state <= state_code;
         rsp_phase      <= phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_fire) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

endmodule
`default_nettype wire

[dv/servo_ramp_trigger_controller_unit_test.sv]
module servo_ramp_trigger_controller_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import srtc_pkg::*;

   localparam int SCALE_MAX = 65535;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES = 8;
   localparam int TICKS_PER_PHASE = 225;
   localparam int STEP_LUT [17] = '{
      131, 164, 218, 262, 328, 437, 524, 655,
      749, 874, 1049, 1311, 1748, 2621, 5243, 13107,
      26214
   };

   typedef struct packed {
      logic [6:0]  pad;
      logic        trigger_pin;
      logic [15:0] travel_time;
      logic [15:0] pos_b;
      logic [15:0] pos_a;
   } tick_word_type;

   typedef struct packed {
      logic        pad;
      logic [15:0] phase;
      logic [2:0]  ramp_state;
      logic [11:0] pulse_us;
   } servo_beat_type;

   typedef enum bit {ROW_TICK, ROW_CSR} row_kind_type;
   typedef enum int {RX_OPEN, RX_SPARSE, RX_COIN, RX_HOLD} rx_mode_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   idx;
      logic [10:0]  val;
      logic [15:0]  pos_a;
      logic [15:0]  pos_b;
      logic [15:0]  travel;
      logic         pin;
      bit           typed;
      logic [11:0]  pulse;
      logic [2:0]   ramp;
      logic [15:0]  phase;
   } dir_row_type;

   // Reset settings: bistable, trigger active low, 1000 us minimum and span.
   dir_row_type opening_rows [33] = '{
      '{ROW_TICK, '0, '0, 0, 65535, 16'h0000, 1, 1, 1000, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'h0000, 0, 1, 1000, RAMP_CODE_ATOB, 0},
      // Trigger drops in a to b and the phasor clamps at zero at once.
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 1000, RAMP_CODE_ATTOP, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 1000, RAMP_CODE_BTOA, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 0, 1, 2000, RAMP_CODE_ATTOP, 65535},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 2000, RAMP_CODE_BTOA, 65535},
      // Trigger rises in b to a and the phasor clamps at full scale at once.
      '{ROW_TICK, '0, '0, 0, 65535, 16'h0000, 0, 1, 2000, RAMP_CODE_IDLE, 65535},
      '{ROW_TICK, '0, '0, 65535, 0, 16'h0000, 1, 1, 1000, RAMP_CODE_IDLE, 65535},
      '{ROW_TICK, '0, '0, 65535, 65535, 16'h0000, 1, 1, 2000, RAMP_CODE_IDLE, 65535},
      '{ROW_CSR, CSR_BISTABLE_MODE, 0, 0, 0, 0, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_CSR, CSR_TRIGGER_ACTIVE_LOW, 0, 0, 0, 0, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 2000, RAMP_CODE_ATOB, 65535},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 0, 1, 2000, RAMP_CODE_BTOA, 65535},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 1000, RAMP_CODE_WAIT, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 1000, RAMP_CODE_WAIT, 0},
      // The wait code means nothing in bistable mode and falls back to idle.
      '{ROW_CSR, CSR_BISTABLE_MODE, 1, 0, 0, 0, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 1000, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 1000, RAMP_CODE_ATOB, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'hFFFF, 1, 1, 2000, RAMP_CODE_ATTOP, 65535},
      // One-shot at b turns around without moving the phasor.
      '{ROW_CSR, CSR_BISTABLE_MODE, 0, 0, 0, 0, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 0, 65535, 16'h0000, 0, 1, 2000, RAMP_CODE_BTOA, 65535},
      '{ROW_CSR, CSR_MIN_PULSE_US, 0, 0, 0, 0, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_CSR, CSR_PULSE_SPAN_US, 2000, 0, 0, 0, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 16'h8000, 16'h7FFF, 16'h0000, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_CSR, CSR_MIN_PULSE_US, 2000, 0, 0, 0, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_CSR, CSR_PULSE_SPAN_US, 0, 0, 0, 0, 0, 0, 0, RAMP_CODE_IDLE, 0},
      '{ROW_TICK, '0, '0, 65535, 0, 16'h0F00, 0, 0, 0, RAMP_CODE_IDLE, 0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [10:0] csr_data = '0;

   // Predictor copy of the block's registers and ramp.
   bit          mode_q;
   bit          act_low_q;
   logic [10:0] min_q;
   logic [10:0] span_q;
   logic [2:0]  ramp_q;
   int          phasor_q;
   bit          rising_q;

   servo_beat_type servo_due [$];
   bit             row_has_exp = 1'b0;
   servo_beat_type row_exp = '0;
   int             ticks_taken = 0;
   int             csr_taken = 0;
   int             mismatches = 0;
   int             cycle_count = 0;
   int             rx_hold = 0;
   rx_mode_type    rx_mode = RX_OPEN;

   servo_ramp_trigger_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Moves the phasor one step in the current direction; true when it clamps.
   function automatic bit ramp_moves(int delta);
      phasor_q = rising_q ? phasor_q + delta : phasor_q - delta;
      if (phasor_q > SCALE_MAX) begin
         phasor_q = SCALE_MAX;
         return 1'b1;
      end
      if (phasor_q < 0) begin
         phasor_q = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic servo_beat_type servo_tick_result(tick_word_type tk);
      servo_beat_type r;
      bit act;
      int seg, frac, slope, delta;
      int pos_a, pos_b, span, rng, off, res;
      pos_a = tk.pos_a;
      pos_b = tk.pos_b;
      span = span_q;
      act = act_low_q ? !tk.trigger_pin : tk.trigger_pin;
      seg = tk.travel_time[15:12];
      frac = tk.travel_time[11:8];
      slope = (STEP_LUT[seg + 1] - STEP_LUT[seg]) / 16;
      delta = STEP_LUT[seg] + slope * frac;
      if (mode_q) begin
         case (ramp_q)
            RAMP_CODE_IDLE: if (act) begin
               ramp_q = RAMP_CODE_ATOB;
               rising_q = 1'b1;
            end
            RAMP_CODE_ATOB: begin
               if (!act) begin
                  ramp_q = RAMP_CODE_BTOA;
                  rising_q = 1'b0;
               end
               if (ramp_moves(delta)) ramp_q = RAMP_CODE_ATTOP;
            end
            RAMP_CODE_ATTOP: if (!act) begin
               ramp_q = RAMP_CODE_BTOA;
               rising_q = 1'b0;
            end
            RAMP_CODE_BTOA: begin
               if (act) begin
                  ramp_q = RAMP_CODE_ATOB;
                  rising_q = 1'b1;
               end
               if (ramp_moves(delta)) ramp_q = RAMP_CODE_IDLE;
            end
            default: ramp_q = RAMP_CODE_IDLE;
         endcase
      end else begin
         case (ramp_q)
            RAMP_CODE_IDLE: if (act) begin
               ramp_q = RAMP_CODE_ATOB;
               rising_q = 1'b1;
            end
            RAMP_CODE_ATOB: if (ramp_moves(delta)) begin
               ramp_q = RAMP_CODE_BTOA;
               rising_q = 1'b0;
            end
            RAMP_CODE_ATTOP: begin
               ramp_q = RAMP_CODE_BTOA;
               rising_q = 1'b0;
            end
            RAMP_CODE_BTOA: if (ramp_moves(delta)) ramp_q = RAMP_CODE_WAIT;
            RAMP_CODE_WAIT: if (!act) ramp_q = RAMP_CODE_IDLE;
            default: ramp_q = RAMP_CODE_IDLE;
         endcase
      end
      rng = ((pos_b - pos_a) * span) / SCALE_MAX;
      off = (pos_a * span) / SCALE_MAX;
      res = (phasor_q * rng) / SCALE_MAX + off;
      r.pad = 1'b0;
      r.pulse_us = 12'(min_q + res);
      r.ramp_state = ramp_q;
      r.phase = phasor_q[15:0];
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      servo_beat_type got, want;
      if (reset) begin
         mode_q = 1'b1;
         act_low_q = 1'b1;
         min_q = 11'd1000;
         span_q = 11'd1000;
         ramp_q = RAMP_CODE_IDLE;
         phasor_q = 0;
         rising_q = 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BISTABLE_MODE:      mode_q = csr_data[0];
               CSR_TRIGGER_ACTIVE_LOW: act_low_q = csr_data[0];
               CSR_MIN_PULSE_US:       min_q = csr_data;
               CSR_PULSE_SPAN_US:      span_q = csr_data;
               default: ;
            endcase
            csr_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (servo_due.size() == 0) begin
               $error("result beat with nothing expected: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = servo_due.pop_front();
               if (got.pulse_us !== want.pulse_us) begin
                  $error("pulse_us: expected %0d, actual %0d", want.pulse_us, got.pulse_us);
                  mismatches++;
               end
               if (got.ramp_state !== want.ramp_state) begin
                  $error("ramp_state: expected %0d, actual %0d",
                         want.ramp_state, got.ramp_state);
                  mismatches++;
               end
               if (got.phase !== want.phase) begin
                  $error("phase: expected %0d, actual %0d", want.phase, got.phase);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = servo_tick_result(req_tdata);
            if (row_has_exp) want = row_exp;
            servo_due.push_back(want);
            ticks_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL servo_ramp_trigger_controller_unit");
         $finish;
      end
   end

   // The receiver switches between open, sparse, coin-flip and held-off stretches.
   always @(negedge clock) begin
      if (rx_hold == 0) begin
         rx_hold = $urandom_range(4, 60);
         rx_mode = rx_mode_type'($urandom_range(0, 3));
      end else begin
         rx_hold--;
      end
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_COIN:   rsp_tready <= 1'($urandom);
         default:   rsp_tready <= 1'b0;
      endcase
   end

   // Holds the tick on the bus until it is taken; valid stays high afterwards.
   task automatic send_tick(tick_word_type tk);
      int seen;
      seen = ticks_taken;
      req_tdata <= tk;
      req_tvalid <= 1'b1;
      do @(negedge clock); while (ticks_taken == seen);
   endtask

   task automatic csr_beat(logic [7:0] idx, logic [10:0] val);
      int seen;
      seen = csr_taken;
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(negedge clock); while (csr_taken == seen);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (servo_due.size() != 0) @(negedge clock);
   endtask

   initial begin
      tick_word_type tk;
      int burst_left, gap, pin_run, min_us, span_us;
      bit pin_level;
      burst_left = 0;
      pin_run = 0;
      pin_level = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening_rows[i]) begin
         if (opening_rows[i].kind == ROW_CSR) begin
            wait_drained();
            csr_beat(opening_rows[i].idx, opening_rows[i].val);
         end else begin
            tk = '0;
            tk.pos_a = opening_rows[i].pos_a;
            tk.pos_b = opening_rows[i].pos_b;
            tk.travel_time = opening_rows[i].travel;
            tk.trigger_pin = opening_rows[i].pin;
            row_has_exp = opening_rows[i].typed;
            row_exp = '0;
            row_exp.pulse_us = opening_rows[i].pulse;
            row_exp.ramp_state = opening_rows[i].ramp;
            row_exp.phase = opening_rows[i].phase;
            send_tick(tk);
         end
      end
      row_has_exp = 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               min_us = 0;
               span_us = 2000;
            end
            1: begin
               min_us = 2000;
               span_us = 2000;
            end
            2: begin
               min_us = 0;
               span_us = 0;
            end
            default: begin
               min_us = $urandom_range(0, 2000);
               span_us = $urandom_range(0, 2000);
            end
         endcase
         wait_drained();
         csr_beat(CSR_BISTABLE_MODE, 11'(ph % 2));
         csr_beat(CSR_TRIGGER_ACTIVE_LOW, 11'((ph / 2) % 2));
         csr_beat(CSR_MIN_PULSE_US, 11'(min_us));
         csr_beat(CSR_PULSE_SPAN_US, 11'(span_us));
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               if (gap > 0) begin
                  req_tvalid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
            end
            burst_left--;
            // The trigger is held for runs of mixed length, some long enough to finish
            // whole ramps, with an occasional noisy sample on top.
            if (pin_run == 0) begin
               pin_level = !pin_level;
               pin_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
                                                     : $urandom_range(1, 15);
            end
            pin_run--;
            tk = '0;
            tk.trigger_pin = ($urandom_range(0, 19) == 0) ? 1'($urandom) : pin_level;
            if ($urandom_range(0, 3) == 0)
               tk.travel_time = 16'($urandom);
            else
               tk.travel_time = {4'($urandom_range(10, 15)), 12'($urandom)};
            if ($urandom_range(0, 9) == 0)
               tk.pos_a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
               tk.pos_a = 16'($urandom);
            if ($urandom_range(0, 9) == 0)
               tk.pos_b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
               tk.pos_b = 16'($urandom);
            send_tick(tk);
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0)
         $display("PASS servo_ramp_trigger_controller_unit");
      else
         $display("FAIL servo_ramp_trigger_controller_unit");
      $finish;
   end

endmodule

[files.f]
hdl/srtc_pkg.sv
hdl/srtc_useq.sv
hdl/srtc_ramp.sv
hdl/srtc_dpath.sv
hdl/servo_ramp_trigger_controller_unit.sv
dv/servo_ramp_trigger_controller_unit_test.sv
